// ===== hdl/decimating_window_sample_fetch_macros.svh =====
// assertion macros for the decimating window sample fetch checker
`ifndef DECIMATING_WINDOW_SAMPLE_FETCH_MACROS_SVH
`define DECIMATING_WINDOW_SAMPLE_FETCH_MACROS_SVH

// same-cycle implication, off while in reset
`define DWSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define DWSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches reset itself
`define DWSF_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dwsf_pkg.sv =====
// shared types and constants of the decimating window sample fetch
package dwsf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POINT_W  = 13;
  localparam int COEFF_W  = 16;
  localparam int LAG_W    = 15;
  localparam int DELAY_W  = 15;
  localparam int DEC_W    = 5;
  localparam int PTS_W    = 14;
  localparam int MODE_W   = 3;
  localparam int CMD_W    = 2;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int KDEC_W   = 17;
  localparam int SPAN_W   = 19;
  localparam int SUB_W    = 18;
  localparam int PROD_W   = 34;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COEFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SCOPE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd4;

  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_DEC    = 2'd1;
  localparam logic [1:0] REG_POINTS = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  localparam logic [DEC_W-1:0] DEC_MAX = 5'd16;
  localparam logic [DEC_W-1:0] DEC_MIN = 5'd1;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_frames;
    logic [DEC_W-1:0]   decimation;
    logic [PTS_W-1:0]   window_points;
    logic [MODE_W-1:0]  source_mode;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [POINT_W-1:0] k;
  } fetch_tag_t;

endpackage

// ===== hdl/dwsf_stream_if.sv =====
// item channels of the decimating window sample fetch
interface dwsf_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [dwsf_pkg::CMD_W-1:0]            cmd;
  logic signed [dwsf_pkg::SAMPLE_W-1:0]  left_sample;
  logic signed [dwsf_pkg::SAMPLE_W-1:0]  right_sample;
  logic [dwsf_pkg::POINT_W-1:0]          point_index;
  logic [dwsf_pkg::COEFF_W-1:0]          coeff;
  logic [dwsf_pkg::LAG_W-1:0]            arrival_lag;

  modport source (output valid, cmd, left_sample, right_sample, point_index, coeff,
                  arrival_lag, input ready);
  modport sink (input valid, cmd, left_sample, right_sample, point_index, coeff,
                arrival_lag, output ready);
endinterface

interface dwsf_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dwsf_pkg::SAMPLE_W-1:0]  sample_a;
  logic signed [dwsf_pkg::SAMPLE_W-1:0]  sample_b;
  logic [dwsf_pkg::POINT_W-1:0]          out_index;
  logic                                  is_last;

  modport source (output valid, sample_a, sample_b, out_index, is_last, input ready);
  modport sink (input valid, sample_a, sample_b, out_index, is_last, output ready);
endinterface

// ===== hdl/dwsf_sram.sv =====
// single-port synchronous ram with registered read data
module dwsf_sram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/dwsf_addr_gen.sv =====
// item capture, write pointer, ring address generation and memory requests
module dwsf_addr_gen #(
  parameter int RING_FRAMES = 32768,
  parameter int MAX_POINTS  = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_acc,
  input  logic [dwsf_pkg::CMD_W-1:0]           cmd,
  input  logic [dwsf_pkg::SAMPLE_W-1:0]        left_sample,
  input  logic [dwsf_pkg::SAMPLE_W-1:0]        right_sample,
  input  logic [dwsf_pkg::POINT_W-1:0]         point_index,
  input  logic [dwsf_pkg::COEFF_W-1:0]         coeff,
  input  logic [dwsf_pkg::LAG_W-1:0]           arrival_lag,
  input  dwsf_pkg::cfg_t                       cfg,
  output logic                                 ring_en,
  output logic                                 ring_we,
  output logic [$clog2(RING_FRAMES)-1:0]       ring_addr,
  output logic [dwsf_pkg::FRAME_W-1:0]         ring_wdata,
  output logic                                 coef_en,
  output logic                                 coef_we,
  output logic [$clog2(MAX_POINTS)-1:0]        coef_addr,
  output logic [dwsf_pkg::COEFF_W-1:0]         coef_wdata,
  output dwsf_pkg::fetch_tag_t                 tag
);

  localparam int RW = $clog2(RING_FRAMES);
  localparam int CW = $clog2(MAX_POINTS);

  logic [dwsf_pkg::DEC_W-1:0]    dec_sat;
  logic [dwsf_pkg::KDEC_W-1:0]   kdec_next;
  logic [dwsf_pkg::SPAN_W-1:0]   span;
  logic [dwsf_pkg::SUB_W-1:0]    sub_next;

  logic                          s1_valid;
  logic [dwsf_pkg::CMD_W-1:0]    s1_cmd;
  logic [dwsf_pkg::SAMPLE_W-1:0] s1_left;
  logic [dwsf_pkg::SAMPLE_W-1:0] s1_right;
  logic [dwsf_pkg::POINT_W-1:0]  s1_k;
  logic [dwsf_pkg::COEFF_W-1:0]  s1_coeff;
  logic [dwsf_pkg::LAG_W-1:0]    s1_lag;
  logic [dwsf_pkg::KDEC_W-1:0]   s1_kdec;
  logic [dwsf_pkg::SUB_W-1:0]    s1_sub;

  logic [RW-1:0]                 write_pos;
  logic                          ring_full;
  logic [RW-1:0]                 fetch_addr;
  logic                          is_write;
  logic                          is_coeff;
  logic                          is_fetch;

  // decimation clamped to 1..16
  always_comb begin
    if (cfg.decimation == '0) begin
      dec_sat = dwsf_pkg::DEC_MIN;
    end else if (cfg.decimation > dwsf_pkg::DEC_MAX) begin
      dec_sat = dwsf_pkg::DEC_MAX;
    end else begin
      dec_sat = cfg.decimation;
    end
  end

  assign kdec_next = dwsf_pkg::KDEC_W'(point_index) * dwsf_pkg::KDEC_W'(dec_sat);
  assign span      = dwsf_pkg::SPAN_W'(cfg.window_points) * dwsf_pkg::SPAN_W'(dec_sat);
  assign sub_next  = dwsf_pkg::SUB_W'(cfg.delay_frames) + dwsf_pkg::SUB_W'(span >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd   <= cmd;
      s1_left  <= left_sample;
      s1_right <= right_sample;
      s1_k     <= point_index;
      s1_coeff <= coeff;
      s1_lag   <= arrival_lag;
      s1_kdec  <= kdec_next;
      s1_sub   <= sub_next;
    end
  end

  assign is_write = s1_valid && (s1_cmd == dwsf_pkg::CMD_WRITE);
  assign is_coeff = s1_valid && (s1_cmd == dwsf_pkg::CMD_COEFF);
  assign is_fetch = s1_valid && (s1_cmd == dwsf_pkg::CMD_FETCH);

  // ring length is a power of two, so the wrap is the natural overflow
  assign fetch_addr = write_pos + RW'(s1_lag) + RW'(s1_kdec) - RW'(s1_sub);

  assign ring_en    = adv && (is_write || is_fetch);
  assign ring_we    = is_write;
  assign ring_addr  = is_write ? write_pos : fetch_addr;
  assign ring_wdata = {s1_right, s1_left};

  assign coef_en    = adv && (is_coeff || is_fetch);
  assign coef_we    = is_coeff;
  assign coef_addr  = CW'(s1_k);
  assign coef_wdata = s1_coeff;

  // frames at or above the write pointer read as zero until the first wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      ring_full <= 1'b0;
    end else if (adv && is_write) begin
      write_pos <= write_pos + RW'(1);
      if (write_pos == RW'(RING_FRAMES - 1)) begin
        ring_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (adv) begin
      tag.valid <= is_fetch;
      tag.hit   <= ring_full || (fetch_addr < write_pos);
      tag.k     <= s1_k;
    end
  end

endmodule

// ===== hdl/dwsf_mix.sv =====
// source selection, coefficient multiply, rounding and output register
module dwsf_mix (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  dwsf_pkg::fetch_tag_t                 tag,
  input  logic [dwsf_pkg::FRAME_W-1:0]         ring_rdata,
  input  logic [dwsf_pkg::COEFF_W-1:0]         coef_rdata,
  input  dwsf_pkg::cfg_t                       cfg,
  output logic                                 out_valid,
  output logic signed [dwsf_pkg::SAMPLE_W-1:0] sample_a,
  output logic signed [dwsf_pkg::SAMPLE_W-1:0] sample_b,
  output logic [dwsf_pkg::POINT_W-1:0]         out_index,
  output logic                                 is_last
);

  logic signed [dwsf_pkg::SAMPLE_W-1:0] l_s;
  logic signed [dwsf_pkg::SAMPLE_W-1:0] r_s;
  logic signed [dwsf_pkg::SAMPLE_W:0]   l_x;
  logic signed [dwsf_pkg::SAMPLE_W:0]   r_x;
  logic signed [dwsf_pkg::COEFF_W:0]    w_s;
  logic signed [dwsf_pkg::SAMPLE_W:0]   op;
  logic signed [dwsf_pkg::PROD_W-1:0]   prod_next;
  logic                                 last_next;

  logic                                 p3_valid;
  logic signed [dwsf_pkg::PROD_W-1:0]   p3_prod;
  logic signed [dwsf_pkg::SAMPLE_W-1:0] p3_l;
  logic signed [dwsf_pkg::SAMPLE_W-1:0] p3_r;
  logic [dwsf_pkg::POINT_W-1:0]         p3_k;
  logic                                 p3_last;

  logic signed [dwsf_pkg::PROD_W:0]     p_ext;
  logic signed [dwsf_pkg::PROD_W:0]     q16;
  logic signed [dwsf_pkg::PROD_W:0]     q15;
  logic signed [dwsf_pkg::PROD_W:0]     r16;
  logic signed [dwsf_pkg::PROD_W:0]     r15;
  logic [dwsf_pkg::SAMPLE_W-1:0]        a_next;
  logic [dwsf_pkg::SAMPLE_W-1:0]        b_next;

  function automatic logic [dwsf_pkg::SAMPLE_W-1:0] sat16(
    input logic signed [dwsf_pkg::PROD_W:0] v
  );
    logic [dwsf_pkg::SAMPLE_W-1:0] res;
    if (v > 35'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -35'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[dwsf_pkg::SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // never-written frames read as zero
  assign l_s = tag.hit ? $signed(ring_rdata[dwsf_pkg::SAMPLE_W-1:0]) : '0;
  assign r_s = tag.hit ? $signed(ring_rdata[dwsf_pkg::FRAME_W-1:dwsf_pkg::SAMPLE_W]) : '0;
  assign l_x = (dwsf_pkg::SAMPLE_W+1)'(l_s);
  assign r_x = (dwsf_pkg::SAMPLE_W+1)'(r_s);
  assign w_s = $signed({1'b0, coef_rdata});

  always_comb begin
    case (cfg.source_mode)
      dwsf_pkg::MODE_DIFF:  op = l_x - r_x;
      dwsf_pkg::MODE_SUM:   op = l_x + r_x;
      dwsf_pkg::MODE_LEFT:  op = l_x;
      dwsf_pkg::MODE_RIGHT: op = r_x;
      default:              op = '0;
    endcase
  end

  assign prod_next = dwsf_pkg::PROD_W'(w_s) * dwsf_pkg::PROD_W'(op);
  assign last_next = (dwsf_pkg::PTS_W'(tag.k) + dwsf_pkg::PTS_W'(1)) == cfg.window_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_prod <= prod_next;
      p3_l    <= l_s;
      p3_r    <= r_s;
      p3_k    <= tag.k;
      p3_last <= last_next;
    end
  end

  // round half up: floor of product plus half an lsb
  assign p_ext = (dwsf_pkg::PROD_W+1)'(p3_prod);
  assign q16   = p_ext + 35'sd32768;
  assign q15   = p_ext + 35'sd16384;
  assign r16   = q16 >>> 16;
  assign r15   = q15 >>> 15;

  always_comb begin
    case (cfg.source_mode)
      dwsf_pkg::MODE_SCOPE: begin
        a_next = p3_l;
        b_next = p3_r;
      end
      dwsf_pkg::MODE_DIFF, dwsf_pkg::MODE_SUM: begin
        a_next = sat16(r16);
        b_next = '0;
      end
      dwsf_pkg::MODE_LEFT, dwsf_pkg::MODE_RIGHT: begin
        a_next = sat16(r15);
        b_next = '0;
      end
      default: begin
        a_next = '0;
        b_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_a  <= a_next;
      sample_b  <= b_next;
      out_index <= p3_k;
      is_last   <= p3_last;
    end
  end

endmodule

// ===== hdl/decimating_window_sample_fetch.sv =====
// top level: decimating window fetch over a stereo frame ring
// path: a fetch item passes the capture, ram read, product and output registers
// throughput: one item per cycle, each item making at most one access to the frame ring
//   ram and one to the coefficient ram, both single-port; a stalled result stalls all
// reset: write pointer, registers and pipeline clear at once; the frame ring reads as
//   zero until written (fill tracking, no clearing pass); coefficients undefined
module decimating_window_sample_fetch #(
  parameter int RING_FRAMES = 32768,
  parameter int MAX_POINTS  = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  dwsf_req_if.sink                      req,
  dwsf_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwsf_pkg::APB_AW-1:0]   paddr,
  input  logic [dwsf_pkg::APB_DW-1:0]   pwdata,
  output logic [dwsf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // both depths must be powers of two: addresses wrap by overflow
  localparam int RW = $clog2(RING_FRAMES);
  localparam int CW = $clog2(MAX_POINTS);

  dwsf_pkg::cfg_t                 cfg;
  logic                           adv;
  logic                           in_acc;
  logic                           cfg_wr;
  logic [1:0]                     reg_sel;

  logic                           ring_en;
  logic                           ring_we;
  logic [RW-1:0]                  ring_addr;
  logic [dwsf_pkg::FRAME_W-1:0]   ring_wdata;
  logic [dwsf_pkg::FRAME_W-1:0]   ring_rdata;
  logic                           coef_en;
  logic                           coef_we;
  logic [CW-1:0]                  coef_addr;
  logic [dwsf_pkg::COEFF_W-1:0]   coef_wdata;
  logic [dwsf_pkg::COEFF_W-1:0]   coef_rdata;
  dwsf_pkg::fetch_tag_t           tag;

  // whole pipeline moves together whenever the output register can take an item
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv && !rst;
  assign in_acc    = req.valid && req.ready;

  // configuration port, register i at byte address 4*i
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_frames  <= '0;
      cfg.decimation    <= dwsf_pkg::DEC_MIN;
      cfg.window_points <= dwsf_pkg::PTS_W'(512);
      cfg.source_mode   <= dwsf_pkg::MODE_LEFT;
    end else if (cfg_wr) begin
      case (reg_sel)
        dwsf_pkg::REG_DELAY:  cfg.delay_frames  <= pwdata[dwsf_pkg::DELAY_W-1:0];
        dwsf_pkg::REG_DEC:    cfg.decimation    <= pwdata[dwsf_pkg::DEC_W-1:0];
        dwsf_pkg::REG_POINTS: cfg.window_points <= pwdata[dwsf_pkg::PTS_W-1:0];
        dwsf_pkg::REG_MODE:   cfg.source_mode   <= pwdata[dwsf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      dwsf_pkg::REG_DELAY:  prdata = dwsf_pkg::APB_DW'(cfg.delay_frames);
      dwsf_pkg::REG_DEC:    prdata = dwsf_pkg::APB_DW'(cfg.decimation);
      dwsf_pkg::REG_POINTS: prdata = dwsf_pkg::APB_DW'(cfg.window_points);
      dwsf_pkg::REG_MODE:   prdata = dwsf_pkg::APB_DW'(cfg.source_mode);
      default:              prdata = '0;
    endcase
  end

  // stage 1 capture and stage 2 address, all ram accesses in one stage so
  // reads always see every earlier write without forwarding
  dwsf_addr_gen #(
    .RING_FRAMES (RING_FRAMES),
    .MAX_POINTS  (MAX_POINTS)
  ) u_addr_gen (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_acc       (in_acc),
    .cmd          (req.cmd),
    .left_sample  (req.left_sample),
    .right_sample (req.right_sample),
    .point_index  (req.point_index),
    .coeff        (req.coeff),
    .arrival_lag  (req.arrival_lag),
    .cfg          (cfg),
    .ring_en      (ring_en),
    .ring_we      (ring_we),
    .ring_addr    (ring_addr),
    .ring_wdata   (ring_wdata),
    .coef_en      (coef_en),
    .coef_we      (coef_we),
    .coef_addr    (coef_addr),
    .coef_wdata   (coef_wdata),
    .tag          (tag)
  );

  // frame ring: left sample in the low half, right in the high half
  dwsf_sram #(
    .WIDTH (dwsf_pkg::FRAME_W),
    .DEPTH (RING_FRAMES)
  ) u_ring (
    .clk   (clk),
    .en    (ring_en),
    .we    (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  // window coefficient store
  dwsf_sram #(
    .WIDTH (dwsf_pkg::COEFF_W),
    .DEPTH (MAX_POINTS)
  ) u_coef (
    .clk   (clk),
    .en    (coef_en),
    .we    (coef_we),
    .addr  (coef_addr),
    .wdata (coef_wdata),
    .rdata (coef_rdata)
  );

  // multiply stage and output register
  dwsf_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tag        (tag),
    .ring_rdata (ring_rdata),
    .coef_rdata (coef_rdata),
    .cfg        (cfg),
    .out_valid  (rsp.valid),
    .sample_a   (rsp.sample_a),
    .sample_b   (rsp.sample_b),
    .out_index  (rsp.out_index),
    .is_last    (rsp.is_last)
  );

endmodule

// ===== hdl/dwsf_checker.sv =====
// port-level checker for the decimating window sample fetch, with its bind
`include "decimating_window_sample_fetch_macros.svh"

module dwsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [dwsf_pkg::CMD_W-1:0]    in_cmd,
  input logic [dwsf_pkg::POINT_W-1:0]  in_point_index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dwsf_pkg::SAMPLE_W-1:0] out_sample_a,
  input logic [dwsf_pkg::SAMPLE_W-1:0] out_sample_b,
  input logic [dwsf_pkg::POINT_W-1:0]  out_index,
  input logic                          out_is_last
);

  logic fetch_acc;
  logic flow_ok;

  assign fetch_acc = in_valid && in_ready && (in_cmd == dwsf_pkg::CMD_FETCH);
  // output empty and no reset: the pipeline advanced at this edge
  assign flow_ok   = !out_valid && !rst;

  `DWSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_sample_a) && $stable(out_sample_b) && $stable(out_is_last), "stalled result changed")
  `DWSF_ASSERT_RESET(a_reset_empty, rst, !out_valid, "result valid right after reset")
  `DWSF_ASSERT_NOW(a_fetch_result, $past(fetch_acc, 4) && $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3), out_valid && (out_index == $past(in_point_index, 4)), "fetch item lost or wrong index")
  `DWSF_ASSERT_NOW(a_no_stray, !$past(fetch_acc, 4) && $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3) && $past(flow_ok, 4), !out_valid, "result without a fetch item")

endmodule

bind decimating_window_sample_fetch dwsf_checker u_dwsf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .in_cmd         (req.cmd),
  .in_point_index (req.point_index),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .out_sample_a   (rsp.sample_a),
  .out_sample_b   (rsp.sample_b),
  .out_index      (rsp.out_index),
  .out_is_last    (rsp.is_last)
);
